@@ design/grid_path_validator_assert.svh @@
// Assertion macros used by the grid path validator RTL.
`ifndef GRID_PATH_VALIDATOR_ASSERT_SVH
`define GRID_PATH_VALIDATOR_ASSERT_SVH
`ifndef SYNTH
// Check cons in the same cycle as ante.
`define GPV_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid path validator check failed");
// Check cons in the cycle after ante.
`define GPV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid path validator check failed");
`else
`define GPV_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define GPV_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ design/gpv_pkg.sv @@
// Types and constants of the grid path validator.
package gpv_pkg;

   localparam int GRID_DIM_DEF = 64;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 7;
   localparam int COUNT_W      = 12;
   localparam int STATUS_W     = 3;
   localparam int COORD_W      = 8;
   localparam int SIZE_W       = 7;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [SIZE_W-1:0]  SIZE_RESET = 7'd64;

   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y = 2'd1;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_WALL  = 2'd1,
      CMD_POINT = 2'd2,
      CMD_END   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_WALL   = 3'd2,
      ST_BOUNDS = 3'd3,
      ST_CROSS  = 3'd4,
      ST_ADJ    = 3'd5
   } status_type;

endpackage

@@ design/gpv_if.sv @@
// Request, response and register write channels of the grid path validator.
interface gpv_req_if import gpv_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                command;
   logic signed [COORD_W-1:0] x;
   logic signed [COORD_W-1:0] y;

   modport source (output valid, command, x, y, input ready);
   modport sink   (input valid, command, x, y, output ready);
endinterface

interface gpv_rsp_if import gpv_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  point_count;
   logic                final_res;

   modport source (output valid, status, point_count, final_res, input ready);
   modport sink   (input valid, status, point_count, final_res, output ready);
endinterface

interface gpv_csr_if import gpv_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ design/grid_path_validator.sv @@
// Top level of the grid path validator.
//
// The block checks a path on a GRID_DIM x GRID_DIM grid against a wall bitmap.
// Each request carries a command (clear, add wall, path point, end path) and a
// signed x/y coordinate, and produces exactly one response with a status, the
// number of accepted path points (saturating at 4095) and a final flag that
// marks the end-of-path verdict. Walls and visited cells live in two row
// memories, one row per y, with a registered read; a request runs as the row
// read issued on acceptance, then the check, which writes the row back and
// loads the response register. A waiting response stalls the check, and no
// new request is taken until the check completes. Every row has a valid bit,
// so clear empties both bitmaps and end path the visited one at once; no clearing
// pass runs after reset. The first error of a path sticks until end path or clear.
// Register size_x (index 0) and size_y (index 1) bound the path; values above
// GRID_DIM act as GRID_DIM. Write them only while the block is idle.
`include "grid_path_validator_assert.svh"

module grid_path_validator import gpv_pkg::*; #(
   parameter int GRID_DIM = GRID_DIM_DEF
) (
   input  logic   clock,
   input  logic   reset,
   gpv_req_if.sink   req_ch,
   gpv_rsp_if.source rsp_ch,
   gpv_csr_if.sink   csr_ch
);

   localparam int IDX_W = $clog2(GRID_DIM);
   localparam int PW    = IDX_W + 1;
   localparam logic [SIZE_W-1:0] GRID_LIM = SIZE_W'(GRID_DIM);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // control state
   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           err_ff, err_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]     prev_x_ff, prev_x_in;
   logic [IDX_W-1:0]     prev_y_ff, prev_y_in;
   logic [GRID_DIM-1:0]  wall_vld_ff, wall_vld_in;
   logic [GRID_DIM-1:0]  vis_vld_ff, vis_vld_in;
   logic [SIZE_W-1:0]    size_x_ff, size_y_ff;

   // payload registers
   cmd_type                   cmd_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff;
   status_type                rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      rsp_final_ff, rsp_final_in;

   // datapath
   logic                 accept, go;
   logic [IDX_W-1:0]     row, col, raddr;
   logic [GRID_DIM-1:0]  wall_q, vis_q, wall_row, vis_row, col_bit;
   logic                 on_grid, in_bounds, wall_hit, crossed, adjacent;
   logic [SIZE_W-1:0]    bound_x, bound_y;
   logic [PW-1:0]        cx, cy, px, py;
   status_type           chk;
   logic                 wall_we, vis_we;

   // ---------------------------------------------------------------------
   // Handshakes: take a request only when idle and out of reset, complete
   // the check once the response register is free or being emptied.
   // ---------------------------------------------------------------------
   assign req_ch.ready = (state_ff == ST_IDLE) && !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign go           = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.point_count = rsp_count_ff;
   assign rsp_ch.final_res   = rsp_final_ff;

   assign csr_ch.ready = !reset;

   // ---------------------------------------------------------------------
   // Row memories. Read the request's row on acceptance, hold the address
   // while the check waits so the read data stays put.
   // ---------------------------------------------------------------------
   assign row   = y_ff[IDX_W-1:0];
   assign col   = x_ff[IDX_W-1:0];
   assign raddr = (state_ff == ST_IDLE) ? req_ch.y[IDX_W-1:0] : row;

   gpv_ram #(.WIDTH(GRID_DIM), .DEPTH(GRID_DIM)) u_wall_ram (
      .clock (clock),
      .we    (wall_we),
      .waddr (row),
      .wdata (wall_row | col_bit),
      .raddr (raddr),
      .rdata (wall_q)
   );

   gpv_ram #(.WIDTH(GRID_DIM), .DEPTH(GRID_DIM)) u_vis_ram (
      .clock (clock),
      .we    (vis_we),
      .waddr (row),
      .wdata (vis_row | col_bit),
      .raddr (raddr),
      .rdata (vis_q)
   );

   // ---------------------------------------------------------------------
   // Point check: wall, bounds, self crossing, adjacency, in that order.
   // A row without its valid bit reads as empty.
   // ---------------------------------------------------------------------
   always_comb begin
      wall_row = wall_vld_ff[row] ? wall_q : '0;
      vis_row  = vis_vld_ff[row] ? vis_q : '0;
      col_bit  = GRID_DIM'(1) << col;

      on_grid = !x_ff[COORD_W-1] && !y_ff[COORD_W-1] &&
                (x_ff[SIZE_W-1:0] < GRID_LIM) && (y_ff[SIZE_W-1:0] < GRID_LIM);

      bound_x = (size_x_ff < GRID_LIM) ? size_x_ff : GRID_LIM;
      bound_y = (size_y_ff < GRID_LIM) ? size_y_ff : GRID_LIM;
      in_bounds = !x_ff[COORD_W-1] && !y_ff[COORD_W-1] &&
                  (x_ff[SIZE_W-1:0] < bound_x) && (y_ff[SIZE_W-1:0] < bound_y);

      wall_hit = on_grid && wall_row[col];
      crossed  = vis_row[col];

      cx = PW'(col);
      cy = PW'(row);
      px = PW'(prev_x_ff);
      py = PW'(prev_y_ff);
      adjacent = ((cx == px) && ((cy == py + PW'(1)) || (py == cy + PW'(1)))) ||
                 ((cy == py) && ((cx == px + PW'(1)) || (px == cx + PW'(1))));

      if (wall_hit) begin
         chk = ST_WALL;
      end else if (!in_bounds) begin
         chk = ST_BOUNDS;
      end else if (crossed) begin
         chk = ST_CROSS;
      end else if ((count_ff != '0) && !adjacent) begin
         chk = ST_ADJ;
      end else begin
         chk = ST_OK;
      end
   end

   assign wall_we = go && (cmd_ff == CMD_WALL) && on_grid;
   assign vis_we  = go && (cmd_ff == CMD_POINT) && (err_ff == ST_OK) && (chk == ST_OK);

   // ---------------------------------------------------------------------
   // Next state and response.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      err_in        = err_ff;
      count_in      = count_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      wall_vld_in   = wall_vld_ff;
      vis_vld_in    = vis_vld_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_final_in  = rsp_final_ff;
      rsp_valid_in  = rsp_ch.ready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_status_in = err_ff;
               rsp_count_in  = count_ff;
               rsp_final_in  = 1'b0;
               case (cmd_ff)
                  CMD_CLEAR: begin
                     // drop walls and the whole path
                     wall_vld_in   = '0;
                     vis_vld_in    = '0;
                     err_in        = ST_OK;
                     count_in      = '0;
                     prev_x_in     = '0;
                     prev_y_in     = '0;
                     rsp_status_in = ST_OK;
                     rsp_count_in  = '0;
                  end
                  CMD_WALL: begin
                     if (on_grid) begin
                        wall_vld_in[row] = 1'b1;
                     end
                  end
                  CMD_POINT: begin
                     if (err_ff == ST_OK) begin
                        if (chk != ST_OK) begin
                           err_in        = chk;
                           rsp_status_in = chk;
                        end else begin
                           vis_vld_in[row] = 1'b1;
                           prev_x_in       = col;
                           prev_y_in       = row;
                           if (count_ff != COUNT_MAX) begin
                              count_in     = count_ff + COUNT_W'(1);
                              rsp_count_in = count_ff + COUNT_W'(1);
                           end
                        end
                     end
                  end
                  default: begin
                     // end of path: give the verdict, then drop the path state
                     if (err_ff == ST_OK) begin
                        rsp_status_in = (count_ff == '0) ? ST_EMPTY : ST_OK;
                     end
                     rsp_final_in = 1'b1;
                     vis_vld_in   = '0;
                     err_in       = ST_OK;
                     count_in     = '0;
                     prev_x_in    = '0;
                     prev_y_in    = '0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         err_ff       <= ST_OK;
         count_ff     <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         wall_vld_ff  <= '0;
         vis_vld_ff   <= '0;
         size_x_ff    <= SIZE_RESET;
         size_y_ff    <= SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         err_ff       <= err_in;
         count_ff     <= count_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         wall_vld_ff  <= wall_vld_in;
         vis_vld_ff   <= vis_vld_in;
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (csr_ch.index)
               REG_SIZE_X: size_x_ff <= csr_ch.data;
               REG_SIZE_Y: size_y_ff <= csr_ch.data;
               default: ;
            endcase
         end
      end
   end

   // hold the request while it is checked, and register the response fields
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_ch.command);
         x_ff   <= req_ch.x;
         y_ff   <= req_ch.y;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_final_ff  <= rsp_final_in;
   end

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   `GPV_ASSERT_SAME(a_prev_on_grid, clock, reset, count_ff != '0, (px < PW'(GRID_DIM)) && (py < PW'(GRID_DIM)))
   `GPV_ASSERT_NEXT(a_error_sticky, clock, reset, (err_ff != ST_OK) && !(go && ((cmd_ff == CMD_END) || (cmd_ff == CMD_CLEAR))), $stable(err_ff))
   `GPV_ASSERT_NEXT(a_end_clears_path, clock, reset, go && (cmd_ff == CMD_END), (count_ff == '0) && (err_ff == ST_OK) && (vis_vld_ff == '0))

endmodule

@@ design/gpv_ram.sv @@
// Simple dual-port RAM, one write port and one registered read port.
module gpv_ram import gpv_pkg::*; #(
   parameter int WIDTH = GRID_DIM_DEF,
   parameter int DEPTH = GRID_DIM_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
